@@ hw/rtl/jtsl_pkg.sv @@
// Shared types and constants of the JSON token span lexer.
package jtsl_pkg;

    // Line limit and the widths that follow from it
    localparam int MAX_LINE = 4096;
    localparam int COL_W    = $clog2(MAX_LINE);
    localparam int CNT_W    = $clog2(MAX_LINE + 1);
    localparam int LEN_W    = $clog2(MAX_LINE + 1);

    // Result queue between the lexer step and the output port
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Lexer modes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_STR       = 3'd1;
    localparam logic [2:0] MODE_STR_ESC   = 3'd2;
    localparam logic [2:0] MODE_AFTER_STR = 3'd3;
    localparam logic [2:0] MODE_NUM       = 3'd4;
    localparam logic [2:0] MODE_MINUS     = 3'd5;
    localparam logic [2:0] MODE_KW        = 3'd6;

    // Token classes
    localparam logic [2:0] CLS_KEY     = 3'd0;
    localparam logic [2:0] CLS_STRING  = 3'd1;
    localparam logic [2:0] CLS_NUMBER  = 3'd2;
    localparam logic [2:0] CLS_KEYWORD = 3'd3;
    localparam logic [2:0] CLS_PUNCT   = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0] span_start;
        logic [LEN_W-1:0] span_length;
        logic [2:0]       token_class;
        logic             line_overflow;
        logic             last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [2:0]       lex_mode;
        logic [CNT_W-1:0] column;
        logic [COL_W-1:0] token_start;
        logic [COL_W-1:0] string_end;
        logic [1:0]       keyword_which;
        logic [2:0]       keyword_index;
        logic             prev_alnum;
        logic             overflow_seen;
    } t_lex_state;

    // Spans caused by one character: up to two
    typedef struct packed {
        logic [1:0] count;
        t_out_word  word0;
        t_out_word  word1;
    } t_step_res;

    localparam t_lex_state LEX_RESET = '{
        lex_mode:      MODE_IDLE,
        column:        '0,
        token_start:   '0,
        string_end:    '0,
        keyword_which: 2'd0,
        keyword_index: 3'd0,
        prev_alnum:    1'b0,
        overflow_seen: 1'b0
    };

endpackage

@@ hw/rtl/jtsl_step.sv @@
// Next-state and span logic of the lexer for one character.
module jtsl_step (
    input  jtsl_pkg::t_lex_state i_state,
    input  jtsl_pkg::t_in_word   i_word,
    output jtsl_pkg::t_lex_state o_next,
    output jtsl_pkg::t_step_res  o_res
);
    import jtsl_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20) || (c == 8'h85)
            || (c == 8'hA0);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A))
            || ((c >= 8'h61) && (c <= 8'h7A))
            || (c == 8'hAA) || (c == 8'hB2) || (c == 8'hB3) || (c == 8'hB5)
            || (c == 8'hB9) || (c == 8'hBA) || ((c >= 8'hBC) && (c <= 8'hBE))
            || ((c >= 8'hC0) && (c != 8'hD7) && (c != 8'hF7));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK)
            || (c == CH_RBRACK) || (c == CH_COLON) || (c == CH_COMMA);
    endfunction

    // Keyword spelling, indexed by keyword and letter position
    function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (w)
            KW_TRUE: begin
                unique case (idx)
                    3'd1:    ch = 8'h72;
                    3'd2:    ch = 8'h75;
                    3'd3:    ch = 8'h65;
                    default: ch = 8'h74;
                endcase
            end
            KW_FALSE: begin
                unique case (idx)
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h65;
                    default: ch = 8'h66;
                endcase
            end
            default: begin
                unique case (idx)
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6C;
                    3'd3:    ch = 8'h6C;
                    default: ch = 8'h6E;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] w);
        return (w == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic t_out_word make_span(input logic [COL_W-1:0] first,
                                            input logic [COL_W-1:0] last_col,
                                            input logic [2:0] cls);
        t_out_word w;
        w.span_start    = first;
        w.span_length   = LEN_W'(last_col - first) + LEN_W'(1);
        w.token_class   = cls;
        w.line_overflow = 1'b0;
        w.last_of_run   = 1'b0;
        return w;
    endfunction

    logic [7:0]       ch;
    logic             alnum;
    logic [COL_W-1:0] pos;
    t_lex_state       st;
    logic             fresh_go;
    logic             pa_fresh;
    logic             pend_go;
    logic [2:0]       pend_cls;
    t_out_word        res [2];
    logic [1:0]       n;

    always_comb begin
        ch       = i_word.char_code;
        alnum    = is_alnum(ch);
        st       = i_state;
        fresh_go = 1'b0;
        pa_fresh = i_state.prev_alnum;
        pend_go  = 1'b0;
        pend_cls = CLS_STRING;
        n        = 2'd0;
        res[0]   = '0;
        res[1]   = '0;

        // Saturate the column at the line limit
        if (i_state.column >= CNT_W'(MAX_LINE)) begin
            st.overflow_seen = 1'b1;
            pos = COL_W'(MAX_LINE - 1);
        end else begin
            pos = i_state.column[COL_W-1:0];
            st.column = i_state.column + CNT_W'(1);
        end

        // Advance the token in progress
        unique case (i_state.lex_mode)
            MODE_STR: begin
                st.string_end = pos;
                if (ch == CH_BSLASH) begin
                    st.lex_mode = MODE_STR_ESC;
                end else if (ch == CH_QUOTE) begin
                    st.lex_mode = MODE_AFTER_STR;
                end
            end
            MODE_STR_ESC: begin
                st.string_end = pos;
                st.lex_mode   = MODE_STR;
            end
            MODE_AFTER_STR: begin
                if (!is_space(ch)) begin
                    pend_go  = 1'b1;
                    pend_cls = (ch == CH_COLON) ? CLS_KEY : CLS_STRING;
                    fresh_go = 1'b1;
                end
            end
            MODE_NUM: begin
                if (is_digit(ch) || ch == CH_DOT || ch == CH_LOW_E || ch == CH_UP_E
                    || ch == CH_PLUS || ch == CH_MINUS) begin
                    st.string_end = pos;
                end else begin
                    pend_go  = 1'b1;
                    pend_cls = CLS_NUMBER;
                    fresh_go = 1'b1;
                end
            end
            MODE_MINUS: begin
                if (is_digit(ch)) begin
                    st.lex_mode   = MODE_NUM;
                    st.string_end = pos;
                end else begin
                    fresh_go = 1'b1;
                end
            end
            MODE_KW: begin
                if (i_state.keyword_index < kw_len(i_state.keyword_which)) begin
                    if (ch == kw_char(i_state.keyword_which, i_state.keyword_index)) begin
                        st.keyword_index = i_state.keyword_index + 3'd1;
                        st.string_end    = pos;
                    end else begin
                        pa_fresh = 1'b1;
                        fresh_go = 1'b1;
                    end
                end else if (!alnum) begin
                    pend_go  = 1'b1;
                    pend_cls = CLS_KEYWORD;
                    fresh_go = 1'b1;
                end else begin
                    pa_fresh = 1'b1;
                    fresh_go = 1'b1;
                end
            end
            default: begin
                fresh_go = 1'b1;
            end
        endcase

        // Report the finished token
        if (pend_go) begin
            res[n[0]] = make_span(st.token_start, st.string_end, pend_cls);
            n = n + 2'd1;
        end

        // Lex the character afresh
        if (fresh_go) begin
            st.lex_mode = MODE_IDLE;
            if (ch == CH_QUOTE) begin
                st.lex_mode    = MODE_STR;
                st.token_start = pos;
                st.string_end  = pos;
            end else if (is_digit(ch)) begin
                st.lex_mode    = MODE_NUM;
                st.token_start = pos;
                st.string_end  = pos;
            end else if (ch == CH_MINUS) begin
                st.lex_mode    = MODE_MINUS;
                st.token_start = pos;
                st.string_end  = pos;
            end else if ((ch == CH_LOW_T || ch == CH_LOW_F || ch == CH_LOW_N) && !pa_fresh) begin
                st.lex_mode      = MODE_KW;
                st.token_start   = pos;
                st.string_end    = pos;
                st.keyword_which = (ch == CH_LOW_T) ? KW_TRUE
                                 : (ch == CH_LOW_F) ? KW_FALSE : KW_NULL;
                st.keyword_index = 3'd1;
            end else if (is_punct(ch)) begin
                res[n[0]] = make_span(pos, pos, CLS_PUNCT);
                n = n + 2'd1;
            end
        end
        st.prev_alnum = alnum;

        // Flush the pending token at line end
        if (i_word.line_end) begin
            if (st.lex_mode == MODE_STR || st.lex_mode == MODE_STR_ESC
                || st.lex_mode == MODE_AFTER_STR) begin
                res[n[0]] = make_span(st.token_start, st.string_end, CLS_STRING);
                n = n + 2'd1;
            end else if (st.lex_mode == MODE_NUM) begin
                res[n[0]] = make_span(st.token_start, st.string_end, CLS_NUMBER);
                n = n + 2'd1;
            end else if (st.lex_mode == MODE_KW
                         && st.keyword_index >= kw_len(st.keyword_which)) begin
                res[n[0]] = make_span(st.token_start, st.string_end, CLS_KEYWORD);
                n = n + 2'd1;
            end
        end

        // Stamp overflow and the end of the run
        res[0].line_overflow = st.overflow_seen;
        res[1].line_overflow = st.overflow_seen;
        res[0].last_of_run   = (n == 2'd1);
        res[1].last_of_run   = (n == 2'd2);

        o_res.count = n;
        o_res.word0 = res[0];
        o_res.word1 = res[1];
        o_next      = i_word.line_end ? LEX_RESET : st;
    end

endmodule

@@ hw/rtl/jtsl_out_queue.sv @@
// Result queue: takes up to two span words per cycle, delivers one per cycle while the receiver is ready.
module jtsl_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jtsl_pkg::t_step_res i_push,
    input  logic               i_push_en,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output jtsl_pkg::t_out_word o_word
);
    import jtsl_pkg::*;

    t_out_word         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic [1:0]        push_n;
    logic              pop;

    // Keep room for two words before taking a character
    assign o_room  = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign push_n  = i_push_en ? i_push.count : 2'd0;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(push_n);
        n_rd_ptr = pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    // Store the words of this character
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.word0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push.word1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hw/rtl/json_token_span_lexer_unit.sv @@
// Top level of the JSON token span lexer.
// Takes one Latin-1 character per clock while ready and returns the JSON
// token spans of each line as (start column, length, class), with a
// line-overflow flag and a flag on the last span that a character causes.
// The lexer state updates in the cycle a character word is taken, so a new
// character can follow every clock while the queue has room; spans enter a
// four-word queue and leave one word per clock while the output is ready.
// A character may cause two spans, so the sustained rate is one character
// per cycle while each causes at most one span and the output is ready.
// Input ready drops when the queue has fewer than two free places; spans
// are registered in the queue before output. Columns saturate at 4095.
module json_token_span_lexer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jtsl_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jtsl_pkg::t_out_word o_out_word
);
    import jtsl_pkg::*;

    t_lex_state r_state;
    t_lex_state n_state;
    t_step_res  step_res;
    logic       accept;

    assign accept = i_in_valid && o_in_ready;

    jtsl_step u_step (
        .i_state (r_state),
        .i_word  (i_in_word),
        .o_next  (n_state),
        .o_res   (step_res)
    );

    jtsl_out_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (step_res),
        .i_push_en (accept),
        .o_room    (o_in_ready),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_word    (o_out_word)
    );

    // Advance the lexer state on each taken character word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LEX_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

endmodule

@@ test/json_token_span_lexer_unit_test.sv @@
// Self-checking testbench of the JSON token span lexer: directed table, random lines, long lines.
module json_token_span_lexer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jtsl_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 8;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_ROWS     = 24;

    // One row of the directed table: character, line end, and an optional typed-in span
    typedef struct packed {
        logic [7:0]       ch;
        logic             last;
        logic             typed;
        logic [COL_W-1:0] s;
        logic [LEN_W-1:0] len;
        logic [2:0]       cls;
    } t_dir_row;

    // One character word queued for the sender
    typedef struct packed {
        t_in_word         w;
        logic             typed;
        logic [COL_W-1:0] t_start;
        logic [LEN_W-1:0] t_len;
        logic [2:0]       t_cls;
        logic             fast;
    } t_char_job;

    localparam t_dir_row [0:DIR_ROWS-1] DIR_TABLE = {
        // punctuation on a line of its own, then a one-digit number closed by the line end
        {"{",   1'b0, 1'b1, 12'd0, 13'd1, CLS_PUNCT},
        {",",   1'b0, 1'b1, 12'd1, 13'd1, CLS_PUNCT},
        {"]",   1'b1, 1'b1, 12'd2, 13'd1, CLS_PUNCT},
        {"7",   1'b1, 1'b1, 12'd0, 13'd1, CLS_NUMBER},
        // key with whitespace before the colon
        {"\"",  1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"a",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"\"",  1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {" ",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {":",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        // lone minus
        {"-",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"x",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        // lowest code, then a keyword that breaks off
        {8'h00, 1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"f",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"a",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"x",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        // negative number ended by the highest code
        {"-",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"5",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {8'hFF, 1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        // string cut by the line end inside an escape
        {"\"",  1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"\\",  1'b1, 1'b0, 12'd0, 13'd0, CLS_KEY},
        // complete keyword at the line end
        {"n",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"u",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"l",   1'b0, 1'b0, 12'd0, 13'd0, CLS_KEY},
        {"l",   1'b1, 1'b0, 12'd0, 13'd0, CLS_KEY}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    json_token_span_lexer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    // Lexer state mirrored by the span predictor
    logic [2:0] lx_mode;
    int         lx_col;
    int         lx_tok_start;
    int         lx_tok_end;
    int         lx_kw_sel;
    int         lx_kw_idx;
    bit         lx_prev_an;
    bit         lx_ovf;

    // Spans caused by the character just lexed
    t_out_word  step_spans [2];
    int         step_cnt;

    t_char_job  char_feed [$];
    t_char_job  offered_q [$];
    t_out_word  span_q [$];

    bit         line_fast;
    bit         rx_fast;
    bit         hold_rx;
    int         n_chars;
    int         n_lines;
    int         n_spans;
    int         n_bad;
    int         n_ovf_spans;
    int         n_in_stalls;
    int         cls_seen [5];
    int         cycle_cnt;

    // Character classes
    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
    endfunction

    function automatic bit is_alnum(logic [7:0] c);
        return is_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
            || c == 8'hAA || c == 8'hB2 || c == 8'hB3 || c == 8'hB5 || c == 8'hB9
            || c == 8'hBA || (c >= 8'hBC && c <= 8'hBE)
            || (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
    endfunction

    function automatic string kw_text(int sel);
        case (sel)
            0:       return "true";
            1:       return "false";
            default: return "null";
        endcase
    endfunction

    function automatic void lexer_clear();
        lx_mode      = MODE_IDLE;
        lx_col       = 0;
        lx_tok_start = 0;
        lx_tok_end   = 0;
        lx_kw_sel    = 0;
        lx_kw_idx    = 0;
        lx_prev_an   = 1'b0;
        lx_ovf       = 1'b0;
    endfunction

    function automatic void add_span(int s, int e, logic [2:0] cls);
        if (step_cnt < 2) begin
            step_spans[step_cnt].span_start  = COL_W'(s);
            step_spans[step_cnt].span_length = LEN_W'(e - s + 1);
            step_spans[step_cnt].token_class = cls;
            step_cnt++;
        end
    endfunction

    // Report the pending token; with both places taken, only relabel the last
    function automatic void close_token(logic [2:0] cls);
        if (step_cnt < 2)
            add_span(lx_tok_start, lx_tok_end, cls);
        else
            step_spans[1].token_class = cls;
    endfunction

    function automatic void start_token(logic [2:0] mode, int pos);
        lx_mode      = mode;
        lx_tok_start = pos;
        lx_tok_end   = pos;
    endfunction

    // Lex a character as if no token were open
    function automatic void lex_fresh(logic [7:0] c, int pos);
        lx_mode = MODE_IDLE;
        if (c == "\"") begin
            start_token(MODE_STR, pos);
        end else if (is_digit(c)) begin
            start_token(MODE_NUM, pos);
        end else if (c == "-") begin
            start_token(MODE_MINUS, pos);
        end else if ((c == "t" || c == "f" || c == "n") && !lx_prev_an) begin
            start_token(MODE_KW, pos);
            lx_kw_sel = (c == "t") ? 0 : (c == "f") ? 1 : 2;
            lx_kw_idx = 1;
        end else if (c == "{" || c == "}" || c == "[" || c == "]" || c == ":" || c == ",") begin
            add_span(pos, pos, CLS_PUNCT);
        end
    endfunction

    // Predict the spans that one character word causes
    function automatic void lex_char(logic [7:0] c, logic last);
        bit    an;
        int    pos;
        int    k;
        string kw;
        an       = is_alnum(c);
        step_cnt = 0;
        if (lx_col >= MAX_LINE) begin
            lx_ovf = 1'b1;
            pos    = MAX_LINE - 1;
        end else begin
            pos = lx_col;
            lx_col++;
        end
        kw = kw_text(lx_kw_sel);
        case (lx_mode)
            MODE_STR: begin
                lx_tok_end = pos;
                if (c == "\\")
                    lx_mode = MODE_STR_ESC;
                else if (c == "\"")
                    lx_mode = MODE_AFTER_STR;
            end
            MODE_STR_ESC: begin
                lx_tok_end = pos;
                lx_mode    = MODE_STR;
            end
            MODE_AFTER_STR: begin
                if (!is_space(c)) begin
                    close_token(c == ":" ? CLS_KEY : CLS_STRING);
                    lex_fresh(c, pos);
                end
            end
            MODE_NUM: begin
                if (is_digit(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-") begin
                    lx_tok_end = pos;
                end else begin
                    close_token(CLS_NUMBER);
                    lex_fresh(c, pos);
                end
            end
            MODE_MINUS: begin
                if (is_digit(c)) begin
                    lx_mode    = MODE_NUM;
                    lx_tok_end = pos;
                end else begin
                    lex_fresh(c, pos);
                end
            end
            MODE_KW: begin
                if (lx_kw_idx < kw.len()) begin
                    if (c == kw[lx_kw_idx]) begin
                        lx_kw_idx++;
                        lx_tok_end = pos;
                    end else begin
                        // broken keyword: drop it and lex the breaking character afresh
                        lx_prev_an = 1'b1;
                        lex_fresh(c, pos);
                    end
                end else if (!an) begin
                    close_token(CLS_KEYWORD);
                    lex_fresh(c, pos);
                end else begin
                    lx_prev_an = 1'b1;
                    lex_fresh(c, pos);
                end
            end
            default: lex_fresh(c, pos);
        endcase
        lx_prev_an = an;

        // Flush what the line end leaves open
        if (last) begin
            kw = kw_text(lx_kw_sel);
            if (lx_mode == MODE_STR || lx_mode == MODE_STR_ESC || lx_mode == MODE_AFTER_STR)
                close_token(CLS_STRING);
            else if (lx_mode == MODE_NUM)
                close_token(CLS_NUMBER);
            else if (lx_mode == MODE_KW && lx_kw_idx >= kw.len())
                close_token(CLS_KEYWORD);
        end
        for (k = 0; k < step_cnt; k++) begin
            step_spans[k].line_overflow = lx_ovf;
            step_spans[k].last_of_run   = (k == step_cnt - 1);
        end
        if (last)
            lexer_clear();
    endfunction

    // Character pickers for the random lines
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(32, 255));
        while (c == "\"" || c == "\\");
        return c;
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 7))
            0:       return 8'h09;
            1:       return 8'h0A;
            2:       return 8'h0B;
            3:       return 8'h0C;
            4:       return 8'h0D;
            5:       return 8'h85;
            6:       return 8'hA0;
            default: return 8'h20;
        endcase
    endfunction

    function automatic logic [7:0] punct_char();
        case ($urandom_range(0, 5))
            0:       return "{";
            1:       return "}";
            2:       return "[";
            3:       return "]";
            4:       return ":";
            default: return ",";
        endcase
    endfunction

    function automatic logic [7:0] alnum_char();
        case ($urandom_range(0, 4))
            0:       return 8'("a" + $urandom_range(0, 25));
            1:       return 8'("A" + $urandom_range(0, 25));
            2:       return 8'("0" + $urandom_range(0, 9));
            3:       return 8'(8'hC0 + $urandom_range(0, 22));
            default: return 8'hAA;
        endcase
    endfunction

    function automatic int draw_gap(bit fast);
        return fast ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic push_char(logic [7:0] c);
        t_char_job job;
        job              = '0;
        job.w.char_code  = c;
        job.fast         = line_fast;
        char_feed.push_back(job);
    endtask

    task automatic close_line();
        t_char_job job;
        job            = char_feed.pop_back();
        job.w.line_end = 1'b1;
        char_feed.push_back(job);
    endtask

    // Append one random token, mostly well formed
    task automatic add_piece();
        int    kind;
        int    n;
        int    k;
        string kw;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            // string, about half of them keys
            push_char("\"");
            n = $urandom_range(0, 6);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    push_char("\\");
                    push_char(8'($urandom_range(0, 255)));
                end else begin
                    push_char(text_char());
                end
            end
            push_char("\"");
            if ($urandom_range(0, 1) == 1) begin
                if ($urandom_range(0, 1) == 1)
                    push_char(space_char());
                push_char(":");
            end
        end else if (kind < 34) begin
            if ($urandom_range(0, 2) == 0)
                push_char("-");
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                push_char(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0) begin
                push_char(".");
                push_char(8'("0" + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 3) == 0) begin
                push_char($urandom_range(0, 1) == 1 ? "e" : "E");
                push_char($urandom_range(0, 1) == 1 ? "+" : "-");
                push_char(8'("0" + $urandom_range(0, 9)));
            end
        end else if (kind < 46) begin
            // keyword, some cut short or running on into a letter or digit
            if ($urandom_range(0, 1) == 1)
                push_char(space_char());
            kw = kw_text($urandom_range(0, 2));
            n  = kw.len();
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n - 1);
            for (k = 0; k < n; k++)
                push_char(kw[k]);
            if ($urandom_range(0, 4) == 0)
                push_char(alnum_char());
        end else if (kind < 62) begin
            push_char(punct_char());
        end else if (kind < 74) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                push_char(space_char());
        end else if (kind < 82) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                push_char(8'($urandom_range(0, 255)));
        end else if (kind < 88) begin
            push_char("-");
            push_char($urandom_range(0, 1) == 1 ? space_char() : alnum_char() | 8'h40);
        end else if (kind < 93) begin
            // unclosed string: the rest of the line belongs to it
            push_char("\"");
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++)
                push_char(text_char());
        end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                push_char(alnum_char());
        end
    endtask

    task automatic compose_line(int target);
        int base;
        line_fast = ($urandom_range(0, 3) == 0);
        base      = char_feed.size();
        while (char_feed.size() - base < target)
            add_piece();
        close_line();
    endtask

    // Take output words, stalling a random number of cycles before each one unless the line is fast
    task automatic drain_spans();
        int gap;
        forever begin
            gap = draw_gap(rx_fast);
            if (gap > 0 || hold_rx) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (hold_rx) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Check output words against the predicted spans and predict on each accepted character
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        t_char_job job;
        int        k;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_ready)
                n_in_stalls++;
            if (o_out_valid && i_out_ready) begin
                if (span_q.size() == 0) begin
                    if (n_bad < REPORT_MAX)
                        $display("stray span: start %0d len %0d class %0d ovf %0b last %0b",
                                 o_out_word.span_start, o_out_word.span_length,
                                 o_out_word.token_class, o_out_word.line_overflow,
                                 o_out_word.last_of_run);
                    n_bad++;
                end else begin
                    want = span_q.pop_front();
                    n_spans++;
                    if (want.token_class < 5)
                        cls_seen[want.token_class]++;
                    if (want.line_overflow)
                        n_ovf_spans++;
                    if (o_out_word.span_start    !== want.span_start
                     || o_out_word.span_length   !== want.span_length
                     || o_out_word.token_class   !== want.token_class
                     || o_out_word.line_overflow !== want.line_overflow
                     || o_out_word.last_of_run   !== want.last_of_run) begin
                        if (n_bad < REPORT_MAX)
                            $display({"span mismatch: expected start %0d len %0d class %0d ",
                                      "ovf %0b last %0b, got start %0d len %0d class %0d ",
                                      "ovf %0b last %0b"},
                                     want.span_start, want.span_length, want.token_class,
                                     want.line_overflow, want.last_of_run,
                                     o_out_word.span_start, o_out_word.span_length,
                                     o_out_word.token_class, o_out_word.line_overflow,
                                     o_out_word.last_of_run);
                        n_bad++;
                    end
                end
            end
            if (i_in_valid && o_in_ready && offered_q.size() != 0) begin
                job = offered_q.pop_front();
                lex_char(i_in_word.char_code, i_in_word.line_end);
                if (job.typed) begin
                    want.span_start    = job.t_start;
                    want.span_length   = job.t_len;
                    want.token_class   = job.t_cls;
                    want.line_overflow = 1'b0;
                    want.last_of_run   = 1'b1;
                    span_q.push_back(want);
                end else begin
                    for (k = 0; k < step_cnt; k++)
                        span_q.push_back(step_spans[k]);
                end
                n_chars++;
                if (i_in_word.line_end)
                    n_lines++;
            end
        end
    end

    initial begin : stimulus
        t_char_job job;
        int        idx;
        int        gap;
        int        line;
        int        short_items;
        int        prior;
        int        k;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        hold_rx     = 1'b0;
        rx_fast     = 1'b0;
        line_fast   = 1'b0;
        n_chars     = 0;
        n_lines     = 0;
        n_spans     = 0;
        n_bad       = 0;
        n_ovf_spans = 0;
        n_in_stalls = 0;
        for (k = 0; k < 5; k++)
            cls_seen[k] = 0;
        lexer_clear();

        // Walk the directed table
        for (idx = 0; idx < DIR_ROWS; idx++) begin
            job             = '0;
            job.w.char_code = DIR_TABLE[idx].ch;
            job.w.line_end  = DIR_TABLE[idx].last;
            job.typed       = DIR_TABLE[idx].typed;
            job.t_start     = DIR_TABLE[idx].s;
            job.t_len       = DIR_TABLE[idx].len;
            job.t_cls       = DIR_TABLE[idx].cls;
            char_feed.push_back(job);
        end

        // Random lines, with long lines in the middle to reach the column limit
        short_items = 0;
        for (line = 0; short_items < RANDOM_ITEMS; line++) begin
            if (line == 15) begin
                // tokens past the column limit
                compose_line(MAX_LINE + 60);
                // closed string filling the line exactly
                line_fast = 1'b0;
                push_char("\"");
                for (k = 0; k < MAX_LINE - 2; k++)
                    push_char(text_char());
                push_char("\"");
                close_line();
                // unclosed string running past the limit
                push_char("\"");
                for (k = 0; k < MAX_LINE + 20; k++)
                    push_char(text_char());
                close_line();
            end
            prior = char_feed.size();
            compose_line($urandom_range(1, 40));
            short_items += char_feed.size() - prior;
        end

        // Hold reset, then start the receiver and the long output stall
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_spans();
            begin
                wait (n_chars >= 120);
                hold_rx = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join_none

        // Offer each character word, keeping valid high across back-to-back words
        for (idx = 0; idx < char_feed.size(); idx++) begin
            job = char_feed[idx];
            gap = draw_gap(job.fast);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_word  <= job.w;
            offered_q.push_back(job);
            rx_fast = job.fast;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;

        // Drain, then keep watching for stray words
        while (offered_q.size() != 0 || span_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("lexed %0d characters on %0d lines; %0d spans checked", n_chars, n_lines,
                 n_spans);
        $display({"spans by class: key %0d string %0d number %0d keyword %0d punct %0d; ",
                  "%0d past the column limit; %0d input stall cycles"},
                 cls_seen[0], cls_seen[1], cls_seen[2], cls_seen[3], cls_seen[4],
                 n_ovf_spans, n_in_stalls);
        if (n_bad == 0 && span_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/jtsl_pkg.sv
hw/rtl/jtsl_step.sv
hw/rtl/jtsl_out_queue.sv
hw/rtl/json_token_span_lexer_unit.sv
test/json_token_span_lexer_unit_test.sv
